[design/tlbpa_pkg.sv]
// shared codes and field widths for the two-level bitmap page allocator
package tlbpa_pkg;

  // field widths fixed by the item format
  localparam int ChannelW = 2;
  localparam int PageW    = 8;

  // request codes
  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  // result status codes
  typedef enum logic {
    ST_OK     = 1'b0,
    ST_NOFREE = 1'b1
  } status_t;

endpackage

[design/two_level_bitmap_page_allocator_top.sv]
// two-level bitmap page allocator: per-channel group masks and page free words
// the result of an accepted item is registered in the output register
// throughput: one item per cycle while the output is not stalled; both priority encoders and the bit update
//   sit between the input ports and the state and result registers
// reset: synchronous rst sets every group bit and every page bit (all pages free)
//   and empties the output register
module two_level_bitmap_page_allocator_top #(
  parameter int CHANNELS           = 4,
  parameter int GROUPS_PER_CHANNEL = 8,
  parameter int PAGES_PER_GROUP    = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [tlbpa_pkg::ChannelW-1:0] channel,
  input  logic [tlbpa_pkg::PageW-1:0]    page,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         status,
  output logic [tlbpa_pkg::PageW-1:0]    page_out
);

  localparam int Entries = CHANNELS * GROUPS_PER_CHANNEL;
  localparam int CiW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GiW     = (GROUPS_PER_CHANNEL > 1) ? $clog2(GROUPS_PER_CHANNEL) : 1;
  localparam int BiW     = $clog2(PAGES_PER_GROUP);
  localparam int AW      = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int PageMax = (1 << tlbpa_pkg::PageW) - 1;
  localparam int DivMax  = PageMax / PAGES_PER_GROUP;

  // state
  logic [GROUPS_PER_CHANNEL-1:0] group_mask [CHANNELS];
  logic [PAGES_PER_GROUP-1:0]    words      [Entries];

  logic                          accept;
  logic                          chan_ok;
  logic [CiW-1:0]                chn_idx;
  logic [GROUPS_PER_CHANNEL-1:0] gmask;
  logic [GiW-1:0]                g_sel;
  logic                          g_any;
  logic [tlbpa_pkg::PageW-1:0]   free_g;
  logic [BiW-1:0]                free_b;
  logic                          free_ok;
  logic [AW-1:0]                 addr;
  logic [PAGES_PER_GROUP-1:0]    word;
  logic [BiW-1:0]                b_sel;
  logic                          b_any;
  logic [GiW-1:0]                free_gpos;
  logic [BiW-1:0]                free_bpos;
  logic [GiW-1:0]                sel_gpos;
  logic [BiW-1:0]                sel_bpos;
  logic [GROUPS_PER_CHANNEL-1:0] gmask_next;
  logic [PAGES_PER_GROUP-1:0]    word_next;
  logic                          gmask_we;
  logic                          word_we;
  logic                          status_next;
  logic [tlbpa_pkg::PageW-1:0]   page_out_next;

  // handshake: hold input while the result register is stuck
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // channel decode, out-of-range channels are clamped and gated
  assign chan_ok = int'(channel) < CHANNELS;
  assign chn_idx = chan_ok ? CiW'(channel) : '0;
  assign gmask   = group_mask[chn_idx];

  // first free group, msb first
  always_comb begin
    g_sel = '0;
    g_any = 1'b0;
    for (int i = 0; i < GROUPS_PER_CHANNEL; i++) begin
      if (gmask[i]) begin
        g_sel = GiW'(GROUPS_PER_CHANNEL - 1 - i);
        g_any = 1'b1;
      end
    end
  end

  // split the freed page number into group and bit by constant compares
  always_comb begin
    free_g = '0;
    for (int k = 1; k <= DivMax; k++) begin
      if (int'(page) >= k * PAGES_PER_GROUP) free_g = tlbpa_pkg::PageW'(k);
    end
    free_b  = BiW'(int'(page) - int'(free_g) * PAGES_PER_GROUP);
    free_ok = chan_ok && (int'(free_g) < GROUPS_PER_CHANNEL);
  end

  // one word read, address picked by the request kind
  always_comb begin
    if (action == tlbpa_pkg::ACT_FREE) begin
      addr = AW'(int'(chn_idx) * GROUPS_PER_CHANNEL + int'(free_g));
    end else begin
      addr = AW'(int'(chn_idx) * GROUPS_PER_CHANNEL + int'(g_sel));
    end
  end
  assign word = words[addr];

  // first free page in the word, msb first
  always_comb begin
    b_sel = '0;
    b_any = 1'b0;
    for (int i = 0; i < PAGES_PER_GROUP; i++) begin
      if (word[i]) begin
        b_sel = BiW'(PAGES_PER_GROUP - 1 - i);
        b_any = 1'b1;
      end
    end
  end

  // bit positions inside the mask and the word, counted from the msb
  assign free_gpos = GiW'(GROUPS_PER_CHANNEL - 1 - int'(free_g));
  assign free_bpos = BiW'(PAGES_PER_GROUP - 1 - int'(free_b));
  assign sel_gpos  = GiW'(GROUPS_PER_CHANNEL - 1 - int'(g_sel));
  assign sel_bpos  = BiW'(PAGES_PER_GROUP - 1 - int'(b_sel));

  // state update and result
  always_comb begin
    gmask_next    = gmask;
    word_next     = word;
    gmask_we      = 1'b0;
    word_we       = 1'b0;
    status_next   = tlbpa_pkg::ST_OK;
    page_out_next = '0;
    if (action == tlbpa_pkg::ACT_FREE) begin
      if (free_ok) begin
        gmask_next[free_gpos] = 1'b1;
        word_next[free_bpos]  = 1'b1;
        gmask_we = 1'b1;
        word_we  = 1'b1;
      end
    end else begin
      status_next = tlbpa_pkg::ST_NOFREE;
      if (chan_ok && g_any) begin
        if (b_any) begin
          word_next[sel_bpos] = 1'b0;
          word_we       = 1'b1;
          status_next   = tlbpa_pkg::ST_OK;
          page_out_next = tlbpa_pkg::PageW'(int'(g_sel) * PAGES_PER_GROUP + int'(b_sel));
          if (word_next == '0) begin
            gmask_next[sel_gpos] = 1'b0;
            gmask_we = 1'b1;
          end
        end else begin
          gmask_next[sel_gpos] = 1'b0;
          gmask_we = 1'b1;
        end
      end
    end
  end

  // bitmap registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) group_mask[c] <= '1;
      for (int e = 0; e < Entries; e++) words[e] <= '1;
    end else if (accept) begin
      if (gmask_we) group_mask[chn_idx] <= gmask_next;
      if (word_we) words[addr] <= word_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      page_out <= page_out_next;
    end
  end

endmodule

[design/tlbpa_checker.sv]
// port-level checker for the page allocator, bound to the top level
module tlbpa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           action,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           status,
  input logic [tlbpa_pkg::PageW-1:0]    page_out
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(page_out))
    else $error("result payload changed while stalled");

  // every accepted item shows a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  // a free request always answers success with page zero
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == tlbpa_pkg::ACT_FREE
    |=> status == tlbpa_pkg::ST_OK && page_out == '0)
    else $error("free request gave a nonzero result");

  // a failed allocation reports page zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tlbpa_pkg::ST_NOFREE |-> page_out == '0)
    else $error("no-free result with a page number");

endmodule

bind two_level_bitmap_page_allocator_top tlbpa_checker u_tlbpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .page_out  (page_out)
);
